>>> design/srfpf_pkg.sv
// Shared types, codes and constants for the stereo resonant four-pole filter.
`default_nettype none
package srfpf_pkg;

	localparam int STATE_W = 32;
	localparam int COEF_W  = 16;
	localparam int GAIN_W  = 20;
	localparam int MODE_W  = 2;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;
	localparam int DRIVE_W = 40;
	localparam int PROD_W  = 61;
	localparam int SHIFT   = 16;
	localparam int SUM_W   = PROD_W - SHIFT + 1;

	localparam logic [MODE_W-1:0] MODE_LOW    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_HIGH   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BAND   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_BYPASS = 2'd3;

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_CUTOFF = 2'd1;
	localparam logic [1:0] REG_RES    = 2'd2;

	localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(64'sd2147483647);
	localparam logic signed [SUM_W-1:0] SUM_LO = ~SUM_HI;

	typedef struct packed {
		logic start;
		logic bypass;
		logic ack;
	} lane_ctrl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} lane_stat_t;

	function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
		logic signed [STATE_W-1:0] r;
		if (v > SUM_HI) begin
			r = SUM_HI[STATE_W-1:0];
		end else if (v < SUM_LO) begin
			r = SUM_LO[STATE_W-1:0];
		end else begin
			r = v[STATE_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> design/stereo_resonant_four_pole_filter.sv
// Top level of the stereo filter: config registers, gain unit, two channel lanes, result register.
// A lane steps each beat through feedback, pole and output states; bypass skips straight to done.
// A new frame is taken only when both lanes are idle; each lane's multiplier is shared by all stages.
// A cutoff or resonance write stalls input while the serial divider rebuilds the gain.
// Result register frees the lanes; a finished frame waits there while the next beat is taken.
// Reset: async active low; clears stage state, config registers, gain and valid flags.
`default_nettype none
module stereo_resonant_four_pole_filter #(
	parameter int SAMPLE_BITS = 24,
	parameter int CHANNEL_COUNT = 2,
	parameter int STAGE_COUNT = 4
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0]      left_in,
	input  wire logic signed [SAMPLE_BITS-1:0]      right_in,
	input  wire logic                               block_end,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed [SAMPLE_BITS-1:0]           left_out,
	output logic signed [SAMPLE_BITS-1:0]           right_out,
	output logic                                    block_end_out,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [srfpf_pkg::ADDR_W-1:0]       paddr,
	input  wire logic [srfpf_pkg::DATA_W-1:0]       pwdata,
	output logic [srfpf_pkg::DATA_W-1:0]            prdata,
	output logic                                    pready
);

	localparam bit RIGHT_ON = CHANNEL_COUNT > 1;

	logic [srfpf_pkg::MODE_W-1:0]        mode_q;
	logic [srfpf_pkg::COEF_W-1:0]        cutoff_q;
	logic [srfpf_pkg::COEF_W-1:0]        res_q;
	logic                                gain_start_q;
	logic                                out_valid_q;
	logic                                be_q;
	logic signed [SAMPLE_BITS-1:0]       left_q;
	logic signed [SAMPLE_BITS-1:0]       right_q;
	logic                                be_out_q;

	logic                                wr;
	logic [1:0]                          reg_idx;
	logic                                gain_busy;
	logic [srfpf_pkg::GAIN_W-1:0]        gain;
	logic                                accept;
	logic                                load;
	srfpf_pkg::lane_ctrl_t               l_ctrl;
	srfpf_pkg::lane_ctrl_t               r_ctrl;
	srfpf_pkg::lane_stat_t               l_stat;
	srfpf_pkg::lane_stat_t               r_stat;
	logic signed [SAMPLE_BITS-1:0]       l_y;
	logic signed [SAMPLE_BITS-1:0]       r_y;

	assign pready  = 1'b1;
	assign wr      = psel & penable & pwrite;
	assign reg_idx = paddr[srfpf_pkg::ADDR_W-1:2];

	always_comb begin
		unique case (reg_idx)
			srfpf_pkg::REG_MODE:   prdata = srfpf_pkg::DATA_W'(mode_q);
			srfpf_pkg::REG_CUTOFF: prdata = srfpf_pkg::DATA_W'(cutoff_q);
			srfpf_pkg::REG_RES:    prdata = srfpf_pkg::DATA_W'(res_q);
			default:               prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= srfpf_pkg::MODE_LOW;
			cutoff_q     <= '0;
			res_q        <= '0;
			gain_start_q <= 1'b0;
		end else begin
			gain_start_q <= wr & ((reg_idx == srfpf_pkg::REG_CUTOFF) |
				(reg_idx == srfpf_pkg::REG_RES));
			if (wr) begin
				unique case (reg_idx)
					srfpf_pkg::REG_MODE: begin
						mode_q <= pwdata[srfpf_pkg::MODE_W-1:0];
					end
					srfpf_pkg::REG_CUTOFF: begin
						cutoff_q <= pwdata[srfpf_pkg::COEF_W-1:0];
					end
					srfpf_pkg::REG_RES: begin
						res_q <= pwdata[srfpf_pkg::COEF_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	srfpf_gain u_gain (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gain_start_q),
		.cutoff (cutoff_q),
		.res    (res_q),
		.busy   (gain_busy),
		.gain   (gain)
	);

	assign in_stall = gain_busy | gain_start_q | ~(l_stat.idle & r_stat.idle);
	assign accept   = in_valid & ~in_stall;
	assign load     = l_stat.done & r_stat.done & (~out_valid_q | ~out_stall);

	assign l_ctrl.start  = accept;
	assign l_ctrl.bypass = mode_q == srfpf_pkg::MODE_BYPASS;
	assign l_ctrl.ack    = load;
	assign r_ctrl.start  = accept;
	assign r_ctrl.bypass = (mode_q == srfpf_pkg::MODE_BYPASS) | ~RIGHT_ON;
	assign r_ctrl.ack    = load;

	srfpf_lane #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.STAGE_COUNT (STAGE_COUNT)
	) u_lane_left (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (l_ctrl),
		.mode   (mode_q),
		.cutoff (cutoff_q),
		.gain   (gain),
		.x      (left_in),
		.stat   (l_stat),
		.y      (l_y)
	);

	srfpf_lane #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.STAGE_COUNT (STAGE_COUNT)
	) u_lane_right (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (r_ctrl),
		.mode   (mode_q),
		.cutoff (cutoff_q),
		.gain   (gain),
		.x      (right_in),
		.stat   (r_stat),
		.y      (r_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (~out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			be_q <= block_end;
		end
		if (load) begin
			left_q   <= l_y;
			right_q  <= r_y;
			be_out_q <= be_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign left_out      = left_q;
	assign right_out     = right_q;
	assign block_end_out = be_out_q;

endmodule
`default_nettype wire

>>> design/srfpf_gain.sv
// Resonance feedback gain: bit-serial reciprocal of (1 - cutoff), then scale and saturate.
`default_nettype none
module srfpf_gain (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [srfpf_pkg::COEF_W-1:0]      cutoff,
	input  wire logic [srfpf_pkg::COEF_W-1:0]      res,
	output logic                                   busy,
	output logic [srfpf_pkg::GAIN_W-1:0]           gain
);

	localparam int DIV_STEPS = 33;
	localparam int QW = DIV_STEPS;
	localparam int SW = QW + 1;
	localparam int MW = srfpf_pkg::COEF_W + SW;
	localparam int SHIFT_L = srfpf_pkg::SHIFT;

	localparam logic [1:0] G_IDLE = 2'd0;
	localparam logic [1:0] G_DIV  = 2'd1;
	localparam logic [1:0] G_MUL  = 2'd2;
	localparam logic [1:0] G_FIN  = 2'd3;

	logic [1:0]                        st_q;
	logic [5:0]                        cnt_q;
	logic [16:0]                       rem_q;
	logic [16:0]                       den_q;
	logic [QW-1:0]                     quo_q;
	logic [MW-1:0]                     prod_q;
	logic [srfpf_pkg::GAIN_W-1:0]      gain_q;

	logic [17:0]                       trial;
	logic [17:0]                       diff;
	logic                              fits;
	logic [SW-1:0]                     sum_w;
	logic [MW-SHIFT_L-1:0]             shifted;

	assign trial   = {rem_q, (cnt_q == 6'd0)};
	assign fits    = trial >= {1'b0, den_q};
	assign diff    = trial - {1'b0, den_q};
	assign sum_w   = SW'(17'h10000) + {1'b0, quo_q};
	assign shifted = prod_q[MW-1:SHIFT_L];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= G_IDLE;
			cnt_q  <= '0;
			gain_q <= '0;
		end else if (start) begin
			st_q  <= G_DIV;
			cnt_q <= '0;
		end else begin
			unique case (st_q)
				G_IDLE: begin
					st_q <= G_IDLE;
				end
				G_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(DIV_STEPS - 1)) begin
						st_q <= G_MUL;
					end
				end
				G_MUL: begin
					st_q <= G_FIN;
				end
				G_FIN: begin
					gain_q <= (|shifted[MW-SHIFT_L-1:srfpf_pkg::GAIN_W]) ?
						{srfpf_pkg::GAIN_W{1'b1}} : shifted[srfpf_pkg::GAIN_W-1:0];
					st_q   <= G_IDLE;
				end
				default: begin
					st_q <= G_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= 17'h10000 - {1'b0, cutoff};
			rem_q <= '0;
			quo_q <= '0;
		end else if (st_q == G_DIV) begin
			rem_q <= fits ? diff[16:0] : trial[16:0];
			quo_q <= {quo_q[QW-2:0], fits};
		end
		if (st_q == G_MUL) begin
			prod_q <= MW'(res) * MW'(sum_w);
		end
	end

	assign busy = st_q != G_IDLE;
	assign gain = gain_q;

endmodule
`default_nettype wire

>>> design/srfpf_lane.sv
// One channel lane: four-pole cascade stepped through a shared multiplier.
`default_nettype none
module srfpf_lane #(
	parameter int SAMPLE_BITS = 24,
	parameter int STAGE_COUNT = 4
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire srfpf_pkg::lane_ctrl_t                ctrl,
	input  wire logic [srfpf_pkg::MODE_W-1:0]         mode,
	input  wire logic [srfpf_pkg::COEF_W-1:0]         cutoff,
	input  wire logic [srfpf_pkg::GAIN_W-1:0]         gain,
	input  wire logic signed [SAMPLE_BITS-1:0]        x,
	output srfpf_pkg::lane_stat_t                     stat,
	output logic signed [SAMPLE_BITS-1:0]             y
);

	localparam int IW = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
	localparam int KW = $clog2(STAGE_COUNT + 1);
	localparam int IW_INC = srfpf_pkg::PROD_W - srfpf_pkg::SHIFT;
	localparam logic [IW-1:0] LAST = IW'(STAGE_COUNT - 1);
	localparam logic signed [33:0] OUT_HI = 34'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [33:0] OUT_LO = ~OUT_HI;

	localparam logic [2:0] L_IDLE = 3'd0;
	localparam logic [2:0] L_FB   = 3'd1;
	localparam logic [2:0] L_D0   = 3'd2;
	localparam logic [2:0] L_UP   = 3'd3;
	localparam logic [2:0] L_DK   = 3'd4;
	localparam logic [2:0] L_OUT  = 3'd5;
	localparam logic [2:0] L_DONE = 3'd6;

	logic [2:0]                                  st_q;
	logic [KW-1:0]                               k_q;
	logic signed [srfpf_pkg::STATE_W-1:0]        s_q [STAGE_COUNT];
	logic signed [srfpf_pkg::STATE_W-1:0]        prev_q;
	logic signed [srfpf_pkg::PROD_W-1:0]         prod_q;
	logic signed [SAMPLE_BITS-1:0]               x_q;
	logic signed [SAMPLE_BITS-1:0]               y_q;

	logic [KW-1:0]                               count_w;
	logic [KW-1:0]                               k_next;
	logic signed [srfpf_pkg::STATE_W-1:0]        sk;
	logic signed [IW_INC-1:0]                    inc_w;
	logic signed [srfpf_pkg::DRIVE_W-1:0]        fb_w;
	logic [srfpf_pkg::GAIN_W-1:0]                mul_a;
	logic signed [srfpf_pkg::DRIVE_W-1:0]        mul_b;
	logic signed [srfpf_pkg::PROD_W-1:0]         prod_w;
	logic signed [srfpf_pkg::SUM_W-1:0]          sum_w;
	logic signed [srfpf_pkg::STATE_W-1:0]        new_w;
	logic signed [33:0]                          ov;
	logic signed [SAMPLE_BITS-1:0]               y_w;

	assign count_w = (mode == srfpf_pkg::MODE_BAND) ? KW'(2) : KW'(STAGE_COUNT);
	assign k_next  = k_q + KW'(1);
	assign sk      = s_q[k_q[IW-1:0]];
	assign inc_w   = prod_q[srfpf_pkg::PROD_W-1:srfpf_pkg::SHIFT];
	assign fb_w    = srfpf_pkg::DRIVE_W'(inc_w);
	assign sum_w   = srfpf_pkg::SUM_W'(sk) + srfpf_pkg::SUM_W'(inc_w);
	assign new_w   = srfpf_pkg::sat_state(sum_w);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			L_FB: begin
				mul_a = gain;
				mul_b = srfpf_pkg::DRIVE_W'(s_q[0]) - srfpf_pkg::DRIVE_W'(s_q[1]);
			end
			L_D0: begin
				mul_a = srfpf_pkg::GAIN_W'(cutoff);
				mul_b = srfpf_pkg::DRIVE_W'(x_q) - srfpf_pkg::DRIVE_W'(s_q[0]) + fb_w;
			end
			L_DK: begin
				mul_a = srfpf_pkg::GAIN_W'(cutoff);
				mul_b = srfpf_pkg::DRIVE_W'(prev_q) - srfpf_pkg::DRIVE_W'(sk);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_w = $signed({1'b0, mul_a}) * mul_b;

	always_comb begin
		case (mode)
			srfpf_pkg::MODE_LOW:  ov = 34'(s_q[LAST]);
			srfpf_pkg::MODE_HIGH: ov = 34'(s_q[0]) - 34'(s_q[LAST]);
			default:              ov = 34'(x_q) - 34'(s_q[0]);
		endcase
		if (ov > OUT_HI) begin
			y_w = OUT_HI[SAMPLE_BITS-1:0];
		end else if (ov < OUT_LO) begin
			y_w = OUT_LO[SAMPLE_BITS-1:0];
		end else begin
			y_w = ov[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= L_IDLE;
			k_q  <= '0;
			for (int i = 0; i < STAGE_COUNT; i++) begin
				s_q[i] <= '0;
			end
		end else begin
			unique case (st_q)
				L_IDLE: begin
					if (ctrl.start) begin
						k_q  <= '0;
						st_q <= ctrl.bypass ? L_DONE : L_FB;
					end
				end
				L_FB: begin
					st_q <= L_D0;
				end
				L_D0: begin
					st_q <= L_UP;
				end
				L_UP: begin
					s_q[k_q[IW-1:0]] <= new_w;
					k_q              <= k_next;
					st_q             <= (k_next == count_w) ? L_OUT : L_DK;
				end
				L_DK: begin
					st_q <= L_UP;
				end
				L_OUT: begin
					st_q <= L_DONE;
				end
				L_DONE: begin
					if (ctrl.ack) begin
						st_q <= L_IDLE;
					end
				end
				default: begin
					st_q <= L_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == L_IDLE && ctrl.start) begin
			x_q <= x;
			y_q <= x;
		end
		if (st_q == L_FB || st_q == L_D0 || st_q == L_DK) begin
			prod_q <= prod_w;
		end
		if (st_q == L_UP) begin
			prev_q <= new_w;
		end
		if (st_q == L_OUT) begin
			y_q <= y_w;
		end
	end

	assign stat.idle = st_q == L_IDLE;
	assign stat.done = st_q == L_DONE;
	assign y         = y_q;

endmodule
`default_nettype wire

>>> dv/srfpf_checker.sv
// Scoreboard for the stereo filter: models both channel cascades and checks every output beat.
`timescale 1ns / 100ps
module srfpf_checker #(
	parameter int SAMPLE_BITS = 24,
	parameter int CHANNEL_COUNT = 2,
	parameter int STAGE_COUNT = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic signed [SAMPLE_BITS-1:0]       left_in,
	input  logic signed [SAMPLE_BITS-1:0]       right_in,
	input  logic                                block_end,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic signed [SAMPLE_BITS-1:0]       left_out,
	input  logic signed [SAMPLE_BITS-1:0]       right_out,
	input  logic                                block_end_out,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic                                pready,
	input  logic [srfpf_pkg::ADDR_W-1:0]        paddr,
	input  logic [srfpf_pkg::DATA_W-1:0]        pwdata,
	output int                                  failures,
	output int                                  pending
);

	localparam longint unsigned GAIN_CAP = (64'd1 << srfpf_pkg::GAIN_W) - 1;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left;
		logic signed [SAMPLE_BITS-1:0] right;
		logic                          block_end;
	} frame_t;

	frame_t                               frame_q[$];
	logic [srfpf_pkg::MODE_W-1:0]         mode_reg;
	logic [srfpf_pkg::COEF_W-1:0]         cutoff_reg;
	logic [srfpf_pkg::COEF_W-1:0]         res_reg;
	logic [srfpf_pkg::GAIN_W-1:0]         gain_reg;
	logic signed [srfpf_pkg::STATE_W-1:0] stages [2][4];
	int                                   mismatches;

	function automatic longint clamp_to(longint v, int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic logic [srfpf_pkg::GAIN_W-1:0] resonance_gain(
			logic [srfpf_pkg::COEF_W-1:0] c, logic [srfpf_pkg::COEF_W-1:0] r);
		longint unsigned recip;
		longint unsigned g;
		recip = (64'd1 << 32) / (64'd65536 - 64'(c));
		g = (64'(r) * (64'd65536 + recip)) >> srfpf_pkg::SHIFT;
		if (g > GAIN_CAP) g = GAIN_CAP;
		return g[srfpf_pkg::GAIN_W-1:0];
	endfunction

	function automatic logic signed [srfpf_pkg::STATE_W-1:0] pole_step(
			logic signed [srfpf_pkg::STATE_W-1:0] st, longint drive);
		longint inc;
		inc = (longint'(cutoff_reg) * drive) >>> srfpf_pkg::SHIFT;
		return srfpf_pkg::STATE_W'(clamp_to(longint'(st) + inc, srfpf_pkg::STATE_W));
	endfunction

	function automatic longint filter_channel(int ch, longint x);
		longint fb;
		longint y;
		int     k;
		int     count;
		if (mode_reg == srfpf_pkg::MODE_BYPASS) return x;
		fb = (longint'(gain_reg) * (longint'(stages[ch][0]) - longint'(stages[ch][1])))
			>>> srfpf_pkg::SHIFT;
		stages[ch][0] = pole_step(stages[ch][0], x - longint'(stages[ch][0]) + fb);
		count = (mode_reg == srfpf_pkg::MODE_BAND) ? 2 : STAGE_COUNT;
		for (k = 1; k < count; k++) begin
			stages[ch][k] = pole_step(stages[ch][k],
				longint'(stages[ch][k-1]) - longint'(stages[ch][k]));
		end
		if (mode_reg == srfpf_pkg::MODE_LOW) begin
			y = longint'(stages[ch][STAGE_COUNT-1]);
		end else if (mode_reg == srfpf_pkg::MODE_HIGH) begin
			y = longint'(stages[ch][0]) - longint'(stages[ch][STAGE_COUNT-1]);
		end else begin
			y = x - longint'(stages[ch][0]);
		end
		return y;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_t got;
		frame_t want;
		longint yl;
		longint yr;
		if (!arst_n) begin
			mode_reg = srfpf_pkg::MODE_LOW;
			cutoff_reg = '0;
			res_reg = '0;
			gain_reg = '0;
			stages = '{default: '0};
			frame_q.delete();
			mismatches = 0;
			failures <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[srfpf_pkg::ADDR_W-1:2])
					srfpf_pkg::REG_MODE: begin
						mode_reg = pwdata[srfpf_pkg::MODE_W-1:0];
					end
					srfpf_pkg::REG_CUTOFF: begin
						cutoff_reg = pwdata[srfpf_pkg::COEF_W-1:0];
						gain_reg = resonance_gain(cutoff_reg, res_reg);
					end
					srfpf_pkg::REG_RES: begin
						res_reg = pwdata[srfpf_pkg::COEF_W-1:0];
						gain_reg = resonance_gain(cutoff_reg, res_reg);
					end
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got.left = left_out;
				got.right = right_out;
				got.block_end = block_end_out;
				if (frame_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected output beat: left %0d right %0d end %0b",
							got.left, got.right, got.block_end);
				end else begin
					want = frame_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"beat mismatch: expected left %0d right %0d end %0b,",
								" got left %0d right %0d end %0b"},
								want.left, want.right, want.block_end,
								got.left, got.right, got.block_end);
					end
				end
			end
			if (in_valid && !in_stall) begin
				yl = (CHANNEL_COUNT > 0) ? filter_channel(0, longint'(left_in))
					: longint'(left_in);
				yr = (CHANNEL_COUNT > 1) ? filter_channel(1, longint'(right_in))
					: longint'(right_in);
				want.left = SAMPLE_BITS'(clamp_to(yl, SAMPLE_BITS));
				want.right = SAMPLE_BITS'(clamp_to(yr, SAMPLE_BITS));
				want.block_end = block_end;
				frame_q.push_back(want);
			end
			failures <= mismatches;
			pending <= frame_q.size();
		end
	end

endmodule

>>> dv/testbench.sv
// Stimulus, register setup and verdict for the stereo resonant four-pole filter.
`timescale 1ns / 100ps
module testbench;

	localparam int SAMPLE_BITS = 24;
	localparam int CHANNEL_COUNT = 2;
	localparam int STAGE_COUNT = 4;
	localparam int SEGMENTS = 12;
	localparam int SEGMENT_BEATS = 96;
	localparam int QUIET_LIMIT = 2000;
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam logic signed [SAMPLE_BITS-1:0] FULL_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] FULL_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic signed [SAMPLE_BITS-1:0]    left_in = '0;
	logic signed [SAMPLE_BITS-1:0]    right_in = '0;
	logic                             block_end = 1'b0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic signed [SAMPLE_BITS-1:0]    left_out;
	logic signed [SAMPLE_BITS-1:0]    right_out;
	logic                             block_end_out;
	logic                             psel = 1'b0;
	logic                             penable = 1'b0;
	logic                             pwrite = 1'b0;
	logic [srfpf_pkg::ADDR_W-1:0]     paddr = '0;
	logic [srfpf_pkg::DATA_W-1:0]     pwdata = '0;
	logic [srfpf_pkg::DATA_W-1:0]     prdata;
	logic                             pready;
	int                               failures;
	int                               pending;
	int                               tx_idle = 0;
	int                               rx_idle = 0;
	int                               quiet_cycles = 0;

	always #1 clk = ~clk;

	stereo_resonant_four_pole_filter #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.CHANNEL_COUNT(CHANNEL_COUNT),
		.STAGE_COUNT(STAGE_COUNT)
	) dut (.*);

	srfpf_checker #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.CHANNEL_COUNT(CHANNEL_COUNT),
		.STAGE_COUNT(STAGE_COUNT)
	) scoreboard (.*);

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < rx_idle);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic send_frame(logic signed [SAMPLE_BITS-1:0] l,
			logic signed [SAMPLE_BITS-1:0] r, logic be);
		while ($urandom_range(0, 99) < tx_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		left_in <= l;
		right_in <= r;
		block_end <= be;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [srfpf_pkg::DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= srfpf_pkg::ADDR_W'({idx, 2'b00});
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic configure(logic [srfpf_pkg::MODE_W-1:0] m, logic [srfpf_pkg::COEF_W-1:0] c,
			logic [srfpf_pkg::COEF_W-1:0] r);
		drain();
		write_reg(srfpf_pkg::REG_MODE, srfpf_pkg::DATA_W'({$urandom, m}));
		write_reg(srfpf_pkg::REG_CUTOFF, srfpf_pkg::DATA_W'({$urandom, c}));
		write_reg(srfpf_pkg::REG_RES, srfpf_pkg::DATA_W'({$urandom, r}));
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return FULL_POS;
			1: return FULL_NEG;
			2, 3: return SAMPLE_BITS'($signed($urandom_range(0, 8191)) - 4096);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [srfpf_pkg::COEF_W-1:0] pick_coef();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return srfpf_pkg::COEF_W'($urandom_range(16'hF000, 16'hFFFF));
			default: return srfpf_pkg::COEF_W'($urandom);
		endcase
	endfunction

	function automatic logic [srfpf_pkg::MODE_W-1:0] pick_mode();
		case ($urandom_range(0, 6))
			0, 1: return srfpf_pkg::MODE_LOW;
			2, 3: return srfpf_pkg::MODE_HIGH;
			4, 5: return srfpf_pkg::MODE_BAND;
			default: return srfpf_pkg::MODE_BYPASS;
		endcase
	endfunction

	initial begin
		logic [srfpf_pkg::MODE_W-1:0]  dir_mode [4];
		logic [srfpf_pkg::COEF_W-1:0]  dir_cut [4];
		logic [srfpf_pkg::COEF_W-1:0]  dir_res [4];
		logic signed [SAMPLE_BITS-1:0] l;
		logic signed [SAMPLE_BITS-1:0] r;
		logic signed [SAMPLE_BITS-1:0] hold_l;
		logic signed [SAMPLE_BITS-1:0] hold_r;
		int                            i;
		int                            seg;
		int                            n;
		int                            period;
		dir_mode = '{srfpf_pkg::MODE_LOW, srfpf_pkg::MODE_HIGH, srfpf_pkg::MODE_BAND,
			srfpf_pkg::MODE_BYPASS};
		dir_cut = '{16'h8000, 16'h2000, 16'hC000, 16'h0000};
		dir_res = '{16'h0000, 16'h8000, 16'hFFFF, 16'h4000};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		tx_idle = 11;
		rx_idle = 59;

		// reset settings: zero cutoff, state must stay at zero
		send_frame(FULL_POS, FULL_NEG, 1'b0);
		send_frame(FULL_NEG, FULL_POS, 1'b1);
		drain();
		// writes beyond the last register are dropped
		write_reg(REG_SPARE, $urandom);

		for (i = 0; i < 4; i++) begin
			configure(dir_mode[i], dir_cut[i], dir_res[i]);
			send_frame(FULL_POS, FULL_NEG, 1'b0);
			send_frame(FULL_NEG, FULL_POS, 1'b1);
			send_frame('0, '1, 1'b0);
			send_frame(FULL_POS, FULL_POS, 1'b1);
		end

		// cutoff at its top with full resonance: gain clips
		configure(srfpf_pkg::MODE_LOW, '1, '1);
		send_frame(FULL_POS, FULL_NEG, 1'b0);
		send_frame(FULL_POS, FULL_NEG, 1'b0);
		send_frame(FULL_NEG, FULL_POS, 1'b1);
		send_frame(FULL_NEG, FULL_POS, 1'b1);

		for (seg = 0; seg < SEGMENTS; seg++) begin
			configure(pick_mode(), pick_coef(), pick_coef());
			if (seg < SEGMENTS / 3) begin
				tx_idle = 11;
				rx_idle = 59;
			end else if (seg < 2 * SEGMENTS / 3) begin
				tx_idle = 59;
				rx_idle = 11;
			end else begin
				tx_idle = 0;
				rx_idle = 0;
			end
			period = $urandom_range(2, 24);
			hold_l = pick_sample();
			hold_r = pick_sample();
			for (n = 0; n < SEGMENT_BEATS; n++) begin
				case (seg % 3)
					0: begin
						l = pick_sample();
						r = pick_sample();
					end
					1: begin
						l = ((n / period) % 2) ? FULL_POS : FULL_NEG;
						r = ~l;
					end
					default: begin
						if ($urandom_range(0, 7) == 0) begin
							hold_l = pick_sample();
							hold_r = pick_sample();
						end
						l = hold_l;
						r = hold_r;
					end
				endcase
				send_frame(l, r, $urandom_range(0, 7) == 0);
			end
		end

		drain();
		repeat (2 * STAGE_COUNT + 8) @(posedge clk);
		if (failures == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
